[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error("assertion failed");

`endif

[hdl/lmep_pkg.sv]
// ----------------------------------------------------------------------------
// lmep_pkg
// Types and constants of the list-mode event parser.
// ----------------------------------------------------------------------------
package lmep_pkg;

	typedef enum logic [1:0] {
		KIND_HEADER    = 2'd0,
		KIND_TRACE     = 2'd1,
		KIND_TRUNCATED = 2'd2,
		KIND_MALFORMED = 2'd3
	} kind_t;

	localparam int POS_W      = 14;
	localparam int HDR_W      = 5;
	localparam int REM_W      = 18;
	localparam int LIM_W      = 21;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 176;

	localparam logic [POS_W-1:0] POS_START     = 14'd0;
	localparam logic [POS_W-1:0] POS_TIME_LOW  = 14'd1;
	localparam logic [POS_W-1:0] POS_TIME_HIGH = 14'd2;
	localparam logic [POS_W-1:0] POS_ENERGY    = 14'd3;
	localparam logic [POS_W-1:0] MIN_EVENT_LEN = 14'd4;
	localparam logic [POS_W-1:0] MIN_TRACE_POS = 14'd4;

	typedef struct packed {
		kind_t        kind;
		logic [3:0]   channel;
		logic [3:0]   slot;
		logic [3:0]   crate;
		logic         pileup;
		logic [31:0]  event_number;
		logic [47:0]  timestamp;
		logic [15:0]  cfd;
		logic [15:0]  energy;
		logic [14:0]  trace_len;
		logic         out_of_range;
		logic [31:0]  trace_word;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t data;
	} result_req_t;

endpackage

[hdl/lmep_decode.sv]
// ----------------------------------------------------------------------------
// lmep_decode
// Event state and per-word decode; produces at most one result per word.
// ----------------------------------------------------------------------------
module lmep_decode
	import lmep_pkg::*;
#(
	parameter int BLOCK_WORDS = 131072
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic [31:0]        word,
	input  logic [REM_W-1:0]   words_remaining,
	output result_req_t        res
);

	localparam logic [LIM_W-1:0] BLOCK_LIM = LIM_W'(BLOCK_WORDS);

	logic [POS_W-1:0] pos_q, pos_n;
	logic [POS_W-1:0] ev_words_q, ev_words_n;
	logic [HDR_W-1:0] hdr_words_q, hdr_words_n;
	logic [POS_W-1:0] pairs_q, pairs_n;
	logic             skip_q, skip_n;
	logic [12:0]      src_q, src_n;
	logic [31:0]      time_lo_q, time_lo_n;
	logic [31:0]      time_hi_q, time_hi_n;
	logic [31:0]      count_q, count_n;

	logic [POS_W-1:0] len, pos_inc, adv_pos, trace_start, trace_off;
	logic             adv_wrap, too_short, no_fit;

	always_comb begin
		len       = word[30:17];
		pos_inc   = pos_q + 14'd1;
		adv_wrap  = pos_inc >= ev_words_q;
		adv_pos   = adv_wrap ? POS_START : pos_inc;
		too_short = len < MIN_EVENT_LEN;
		no_fit    = (LIM_W'(len) > LIM_W'(words_remaining)) || (LIM_W'(len) > BLOCK_LIM);
		trace_start = (POS_W'(hdr_words_q) < MIN_TRACE_POS) ? MIN_TRACE_POS
			: POS_W'(hdr_words_q);
		trace_off = pos_q - trace_start;
	end

	always_comb begin
		pos_n       = pos_q;
		ev_words_n  = ev_words_q;
		hdr_words_n = hdr_words_q;
		pairs_n     = pairs_q;
		skip_n      = skip_q;
		src_n       = src_q;
		time_lo_n   = time_lo_q;
		time_hi_n   = time_hi_q;
		count_n     = count_q;
		res         = '0;
		res.data.channel      = src_q[3:0];
		res.data.slot         = src_q[7:4];
		res.data.crate        = src_q[11:8];
		res.data.pileup       = src_q[12];
		res.data.event_number = count_q;
		priority if (pos_q == POS_START) begin
			src_n       = {word[31], word[11:0]};
			hdr_words_n = word[16:12];
			ev_words_n  = len;
			pairs_n     = '0;
			count_n     = count_q + 32'd1;
			res.data.channel      = word[3:0];
			res.data.slot         = word[7:4];
			res.data.crate        = word[11:8];
			res.data.pileup       = word[31];
			res.data.event_number = count_n;
			if (too_short || no_fit) begin
				res.valid     = 1'b1;
				res.data.kind = too_short ? KIND_MALFORMED : KIND_TRUNCATED;
				if (len <= POS_TIME_LOW) begin
					pos_n  = POS_START;
					skip_n = 1'b0;
				end else begin
					pos_n  = POS_TIME_LOW;
					skip_n = 1'b1;
				end
			end else begin
				pos_n  = POS_TIME_LOW;
				skip_n = 1'b0;
			end
		end else begin
			pos_n = adv_pos;
			if (adv_wrap) begin
				skip_n = 1'b0;
			end
			if (!skip_q) begin
				priority if (pos_q == POS_TIME_LOW) begin
					time_lo_n = word;
				end else if (pos_q == POS_TIME_HIGH) begin
					time_hi_n = word;
				end else if (pos_q == POS_ENERGY) begin
					res.valid             = 1'b1;
					res.data.kind         = KIND_HEADER;
					res.data.timestamp    = {time_hi_q[15:0], time_lo_q};
					res.data.cfd          = time_hi_q[31:16];
					res.data.energy       = word[15:0];
					res.data.trace_len    = word[30:16];
					res.data.out_of_range = word[31];
					pairs_n = (ev_words_q > POS_W'(hdr_words_q)) ? POS_W'(word[30:17]) : '0;
				end else if (pos_q >= trace_start && trace_off < pairs_q) begin
					res.valid           = 1'b1;
					res.data.kind       = KIND_TRACE;
					res.data.trace_word = word;
				end else begin
					res.valid = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			ev_words_q  <= '0;
			hdr_words_q <= '0;
			pairs_q     <= '0;
			skip_q      <= 1'b0;
			src_q       <= '0;
			time_lo_q   <= '0;
			time_hi_q   <= '0;
			count_q     <= '0;
		end else if (fire) begin
			pos_q       <= pos_n;
			ev_words_q  <= ev_words_n;
			hdr_words_q <= hdr_words_n;
			pairs_q     <= pairs_n;
			skip_q      <= skip_n;
			src_q       <= src_n;
			time_lo_q   <= time_lo_n;
			time_hi_q   <= time_hi_n;
			count_q     <= count_n;
		end
	end

endmodule

[hdl/list_mode_event_parser.sv]
// ----------------------------------------------------------------------------
// list_mode_event_parser
// Decodes list-mode readout words into header, trace-sample, truncated and malformed results.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata                          tuser
// s_axis    in   word, words_remaining          -
// m_axis    out  event fields and trace word    kind
//
// One word is taken per cycle unless m_axis stalls; a result appears in the cycle after its word.
// A new word enters in the same cycle the pending result is taken.
// A stall on m_axis holds s_axis only while a result is pending.
// Reset clears the event position and counters: the first word is an event start.
// ----------------------------------------------------------------------------
module list_mode_event_parser
	import lmep_pkg::*;
#(
	parameter int BLOCK_WORDS = 131072
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [31:0] word, [49:32] words_remaining, [55:50] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [3:0] channel, [7:4] slot, [11:8] crate, [12] pileup, [44:13] event_number,
	// [92:45] timestamp, [108:93] cfd, [124:109] energy, [139:125] trace_len,
	// [140] out_of_range, [172:141] trace_word, [175:173] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// [1:0] kind
	output logic [1:0]            m_axis_tuser
);

	logic        fire;
	result_req_t res;
	logic        out_valid_q;
	result_t     out_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign fire          = s_axis_tvalid && s_axis_tready;

	lmep_decode #(
		.BLOCK_WORDS(BLOCK_WORDS)
	) u_decode (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.word            (s_axis_tdata[31:0]),
		.words_remaining (s_axis_tdata[49:32]),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= res.valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.valid) begin
			out_q <= res.data;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tdata  = {3'b000, out_q.trace_word, out_q.out_of_range, out_q.trace_len,
		out_q.energy, out_q.cfd, out_q.timestamp, out_q.event_number, out_q.pileup,
		out_q.crate, out_q.slot, out_q.channel};

endmodule

[hdl/lmep_checker.sv]
// ----------------------------------------------------------------------------
// lmep_checker
// Port-level checks of the list-mode event parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lmep_checker
	import lmep_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [1:0]            m_axis_tuser
);

	logic                  out_wait;
	logic                  ready_exp;
	logic                  is_trace;
	logic                  is_header;
	logic                  is_marked;
	logic [OUT_DATA_W+1:0] out_bus;

	assign out_wait  = m_axis_tvalid && !m_axis_tready;
	assign ready_exp = !m_axis_tvalid || m_axis_tready;
	assign is_trace  = m_axis_tvalid && (m_axis_tuser == KIND_TRACE);
	assign is_header = m_axis_tvalid && (m_axis_tuser == KIND_HEADER);
	assign is_marked = m_axis_tvalid &&
		((m_axis_tuser == KIND_TRUNCATED) || (m_axis_tuser == KIND_MALFORMED));
	assign out_bus   = {m_axis_tuser, m_axis_tdata};

	`ASSERT_NEXT(a_hold, clk, arst_n, out_wait, m_axis_tvalid && $stable(out_bus))
	`ASSERT_IMPLY(a_ready, clk, arst_n, 1'b1, s_axis_tready == ready_exp)
	`ASSERT_IMPLY(a_trace_zero, clk, arst_n, is_trace, m_axis_tdata[140:45] == '0)
	`ASSERT_IMPLY(a_header_zero, clk, arst_n, is_header, m_axis_tdata[175:141] == '0)
	`ASSERT_IMPLY(a_marked_zero, clk, arst_n, is_marked, m_axis_tdata[175:45] == '0)

endmodule

bind list_mode_event_parser lmep_checker u_lmep_checker (.*);

[tb/tb_list_mode_event_parser.sv]
// ----------------------------------------------------------------------------
// tb_list_mode_event_parser
// Stream testbench for the list-mode event parser. Readout words are pushed
// in as events built from random fields: well-formed events with traces,
// short and truncated events, cut-off events and loose words. Every accepted
// word runs through a local decoder that queues the expected results. Each
// result taken from the parser is compared field by field with the oldest
// queued one. Both sides idle at random, and the receiver holds off once for
// a long stretch so that the parser fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_list_mode_event_parser;
	import lmep_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BLOCK_WORDS = 131072;
	localparam int QUIET_LIMIT = 2000;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [1:0]            m_axis_tuser;

	int src_idle_pct  = 0;
	int sink_idle_pct = 0;
	logic hold_rx     = 1'b0;
	int words_sent    = 0;
	int fail_count    = 0;
	int quiet_cycles  = 0;

	// decoder state
	logic [13:0] evt_pos     = '0;
	logic [13:0] evt_len     = '0;
	logic [4:0]  hdr_len     = '0;
	logic [13:0] trace_pairs = '0;
	logic        skip_rest   = 1'b0;
	logic [12:0] src_bits    = '0;
	logic [31:0] ts_low      = '0;
	logic [31:0] ts_high_cfd = '0;
	logic [31:0] evt_count   = '0;

	result_t pending_decodes[$];

	list_mode_event_parser #(
		.BLOCK_WORDS(BLOCK_WORDS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		m_axis_tready <= !hold_rx && ($urandom_range(99) >= sink_idle_pct);
	end

	function automatic result_t tag_result(input kind_t k);
		result_t r;
		r              = '0;
		r.kind         = k;
		r.channel      = src_bits[3:0];
		r.slot         = src_bits[7:4];
		r.crate        = src_bits[11:8];
		r.pileup       = src_bits[12];
		r.event_number = evt_count;
		return r;
	endfunction

	task automatic decode_word(input logic [31:0] w, input logic [17:0] rem);
		int          lim;
		int          first_trace;
		logic [13:0] len;
		logic [14:0] tl;
		result_t     r;
		lim = (int'(rem) > BLOCK_WORDS) ? BLOCK_WORDS : int'(rem);
		if (evt_pos == POS_START) begin
			len         = w[30:17];
			src_bits    = {w[31], w[11:0]};
			hdr_len     = w[16:12];
			evt_len     = len;
			trace_pairs = '0;
			evt_count   = evt_count + 32'd1;
			if (len < MIN_EVENT_LEN || int'(len) > lim) begin
				pending_decodes.push_back(
					tag_result(len < MIN_EVENT_LEN ? KIND_MALFORMED : KIND_TRUNCATED));
				skip_rest = (len > 14'd1);
				evt_pos   = (len > 14'd1) ? POS_TIME_LOW : POS_START;
			end else begin
				skip_rest = 1'b0;
				evt_pos   = POS_TIME_LOW;
			end
		end else begin
			if (!skip_rest) begin
				case (evt_pos)
				POS_TIME_LOW:  ts_low = w;
				POS_TIME_HIGH: ts_high_cfd = w;
				POS_ENERGY: begin
					tl             = w[30:16];
					r              = tag_result(KIND_HEADER);
					r.timestamp    = {ts_high_cfd[15:0], ts_low};
					r.cfd          = ts_high_cfd[31:16];
					r.energy       = w[15:0];
					r.trace_len    = tl;
					r.out_of_range = w[31];
					trace_pairs    = (evt_len > hdr_len) ? tl[14:1] : '0;
					pending_decodes.push_back(r);
				end
				default: begin
					first_trace = (hdr_len < MIN_TRACE_POS) ? int'(MIN_TRACE_POS) : int'(hdr_len);
					if (int'(evt_pos) >= first_trace &&
					    int'(evt_pos) - first_trace < int'(trace_pairs)) begin
						r            = tag_result(KIND_TRACE);
						r.trace_word = w;
						pending_decodes.push_back(r);
					end
				end
				endcase
			end
			evt_pos = evt_pos + 14'd1;
			if (evt_pos >= evt_len) begin
				evt_pos   = POS_START;
				skip_rest = 1'b0;
			end
		end
	endtask

	task automatic cmp_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result(input logic [OUT_DATA_W-1:0] data, input logic [1:0] user);
		result_t want;
		if (pending_decodes.size() == 0) begin
			$display("%0t: unexpected result, kind %0d", $time, user);
			fail_count++;
		end else begin
			want = pending_decodes.pop_front();
			cmp_field("kind", want.kind, user);
			cmp_field("channel", want.channel, data[3:0]);
			cmp_field("slot", want.slot, data[7:4]);
			cmp_field("crate", want.crate, data[11:8]);
			cmp_field("pileup", want.pileup, data[12]);
			cmp_field("event_number", want.event_number, data[44:13]);
			cmp_field("timestamp", want.timestamp, data[92:45]);
			cmp_field("cfd", want.cfd, data[108:93]);
			cmp_field("energy", want.energy, data[124:109]);
			cmp_field("trace_len", want.trace_len, data[139:125]);
			cmp_field("out_of_range", want.out_of_range, data[140]);
			cmp_field("trace_word", want.trace_word, data[172:141]);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				decode_word(s_axis_tdata[31:0], s_axis_tdata[49:32]);
			if (m_axis_tvalid && m_axis_tready)
				check_result(m_axis_tdata, m_axis_tuser);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	function automatic logic [17:0] any_rem();
		return 18'($urandom_range(1, BLOCK_WORDS));
	endfunction

	function automatic logic [31:0] make_start(input int len, input int hdr, input int ch,
		input int slot, input int crate, input int pileup);
		return {1'(pileup), 14'(len), 5'(hdr), 4'(crate), 4'(slot), 4'(ch)};
	endfunction

	// called at a falling edge; returns at the falling edge after the request is taken
	task automatic put_word(input logic [31:0] w, input logic [17:0] rem);
		if ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < src_idle_pct)
				@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, rem, w};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic send_event(input int len, input int hdr, input int rem, input int tl,
		input int nwords);
		logic [31:0] w;
		for (int i = 0; i < nwords; i++) begin
			case (i)
			0:       w = make_start(len, hdr, $urandom_range(15), $urandom_range(15),
					$urandom_range(15), $urandom_range(1));
			3:       w = {1'($urandom_range(1)), 15'(tl), 16'($urandom)};
			default: w = $urandom;
			endcase
			put_word(w, (i == 0) ? 18'(rem) : any_rem());
		end
	endtask

	task automatic set_idle(input int src, input int sink);
		src_idle_pct = src;
		sink_idle_pct <= sink;
	endtask

	task automatic test_malformed_lengths();
		for (int len = 0; len < 4; len++) begin
			put_word(make_start(len, 4, len, 15 - len, len, len % 2), any_rem());
			for (int i = 1; i < len; i++)
				put_word($urandom, any_rem());
		end
	endtask

	task automatic test_header_extremes();
		put_word(make_start(4, 4, 15, 15, 15, 1), 18'(BLOCK_WORDS));
		repeat (3)
			put_word('1, 18'(BLOCK_WORDS));
	endtask

	// header length below four, event exactly fills the block
	task automatic test_short_header();
		put_word(make_start(7, 0, 0, 0, 0, 0), 18'd7);
		put_word('0, any_rem());
		put_word('0, any_rem());
		put_word({1'b0, 15'd6, 16'd0}, any_rem());
		repeat (3)
			put_word($urandom, any_rem());
	endtask

	task automatic test_truncated();
		put_word(make_start(5, 4, 3, 9, 6, 0), 18'd4);
		repeat (4)
			put_word($urandom, any_rem());
	endtask

	task automatic test_trace_beyond_event();
		send_event(6, 4, $urandom_range(6, BLOCK_WORDS), 20, 6);
	endtask

	task automatic test_random(input int n);
		int base;
		int pick;
		int len;
		int hdr;
		int first;
		int tl;
		int rem;
		base = words_sent;
		while (words_sent - base < n) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				len   = $urandom_range(4, 40);
				hdr   = ($urandom_range(3) == 0) ? $urandom_range(31) : 4;
				first = (hdr < 4) ? 4 : hdr;
				if ($urandom_range(3) == 0)
					tl = $urandom_range(32767);
				else
					tl = 2 * ((len > first) ? len - first : 0) + $urandom_range(1);
				rem = ($urandom_range(7) == 0) ? len : $urandom_range(len, BLOCK_WORDS);
				send_event(len, hdr, rem, tl, len);
			end else if (pick < 70) begin
				len = $urandom_range(3);
				send_event(len, $urandom_range(31), $urandom_range(1, BLOCK_WORDS),
					$urandom_range(32767), (len <= 1) ? 1 : len);
			end else if (pick < 82) begin
				len = $urandom_range(4, 60);
				send_event(len, $urandom_range(31), $urandom_range(1, len - 1),
					$urandom_range(32767), len);
			end else if (pick < 92) begin
				len = $urandom_range(4, 30);
				send_event(len, 4, BLOCK_WORDS, 2 * len, $urandom_range(1, len - 1));
			end else begin
				// loose words, length field kept short
				repeat ($urandom_range(1, 3))
					put_word($urandom & 32'h807F_FFFF, any_rem());
			end
		end
	endtask

	task automatic test_rx_holdoff();
		fork
			begin
				hold_rx <= 1'b1;
				repeat (400)
					@(negedge clk);
				hold_rx <= 1'b0;
			end
			repeat (4)
				send_event(32, 4, BLOCK_WORDS, 56, 32);
		join
	endtask

	// longest event length; the run ends inside its skipped words
	task automatic test_long_truncated();
		send_event(16383, $urandom_range(31), $urandom_range(1, 16382),
			$urandom_range(32767), 40);
	endtask

	initial begin
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_idle(16, 50);
		test_malformed_lengths();
		test_header_extremes();
		test_short_header();
		test_truncated();
		test_trace_beyond_event();
		test_random(235);
		set_idle(50, 16);
		test_random(235);
		set_idle(0, 0);
		test_random(235);
		test_rx_holdoff();
		test_long_truncated();
		s_axis_tvalid <= 1'b0;
		while (pending_decodes.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
